### hdl/signed_radix_digit_emitter_top_macros.svh
// Assertion macros for the checker file of the digit emitter.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_TOP_MACROS_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_TOP_MACROS_SVH

// Condition that must hold in the same cycle, sampled on clk, off during reset.
`define SDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define SDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sde_pkg.sv
// Shared types, constants and helpers for the signed radix digit emitter.
package sde_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_SYMBOLS  = 32;
  localparam int DEF_NUMBER_WIDTH = 32;

  // Fixed field widths
  localparam int LEN_W      = 6;   // base_length register, radix
  localparam int DIGIT_W    = 5;   // one digit index
  localparam int SYM_W      = 8;   // one symbol byte
  localparam int CFG_DATA_W = 64;  // widest configuration register
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_SLOTS  = 32;  // symbol slots held in the words
  localparam int WORD_SYMS  = 8;   // symbols per symbol word
  localparam int NUM_WORDS  = NUM_SLOTS / WORD_SYMS;
  localparam int DIV_STEP   = 8;   // quotient bits retired per divider cycle

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_WORD_3 = 3'd4;

  // Character codes
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_LF    = 8'h0A;
  localparam logic [SYM_W-1:0] CH_VT    = 8'h0B;
  localparam logic [SYM_W-1:0] CH_FF    = 8'h0C;
  localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;

  // Alphabet symbols by slot
  typedef logic [NUM_SLOTS-1:0][SYM_W-1:0] sym_array_t;

  // Status handed from the configuration block to the sequencer
  typedef struct packed {
    logic             base_ok;
    logic [LEN_W-1:0] radix;
  } cfg_stat_t;

  // Symbols that may not appear in an alphabet
  function automatic logic is_forbidden(input logic [SYM_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SPACE) || (c == CH_TAB) ||
           (c == CH_LF) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF) ||
           (c == CH_NUL);
  endfunction

endpackage

### hdl/signed_radix_digit_emitter_top.sv
// Top level of the signed radix digit emitter: sequencer and output register.
//
// Converts one signed number to text in a configured alphabet, one character
// per result transfer. The input channel (in_valid/in_ready, in_number) takes
// one number at a time; in_ready is high only while no conversion runs. The
// result channel (out_valid/out_ready) carries out_character, out_last_char and
// out_base_error. A negative number gives '-' first, then the digits from most
// to least significant; out_last_char marks the final one. An invalid alphabet
// gives one result with out_base_error and out_last_char set, character zero.
// The shared divider retires 8 quotient bits per cycle, one division per
// digit; for each character the digit store is read, then the symbol looked up.
// Configuration: cfg_we/cfg_index/cfg_wdata, to be written by the user only
// while idle; the block itself does not enforce this.
// Reset (rst_n low, synchronous) clears the control state, drops any conversion
// and empties the output register. A stalled receiver holds the current
// character in the output register and the sequencer waits for it.
module signed_radix_digit_emitter_top import sde_pkg::*; #(
  parameter int MAX_SYMBOLS  = DEF_MAX_SYMBOLS,
  parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [NUMBER_WIDTH-1:0] in_number,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SYM_W-1:0]         out_character,
  output logic                     out_last_char,
  output logic                     out_base_error
);

  localparam int AW = $clog2(NUMBER_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_RD,
    S_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    neg_r, neg_nxt;
  logic [NUMBER_WIDTH-1:0] mag_r, mag_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]        out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  sym_array_t              symbols;
  cfg_stat_t               stat;
  logic                    out_free;
  logic [NUMBER_WIDTH-1:0] num_u;

  logic                    div_start;
  logic [NUMBER_WIDTH-1:0] div_dividend;
  logic                    div_done;
  logic [NUMBER_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]      div_rem;

  logic                    mem_we;
  logic                    mem_re;
  logic [DIGIT_W-1:0]      mem_rdata;

  sde_cfg_regs #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .symbols  (symbols),
    .stat     (stat)
  );

  sde_divider #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (stat.radix),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  sde_digit_mem #(.DEPTH(NUMBER_WIDTH)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(idx_r),
    .wdata(div_rem),
    .re   (mem_re),
    .raddr(idx_r),
    .rdata(mem_rdata)
  );

  assign num_u    = in_number;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Store each remainder as it comes, read back most significant first
  assign mem_we = (state_r == S_DIV) && div_done;
  assign mem_re = (state_r == S_RD);

  // Divider runs on the magnitude first, then on each quotient
  assign div_dividend = (state_r == S_CHECK) ? mag_r : div_quot;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = num_u[NUMBER_WIDTH-1];
          mag_nxt   = num_u[NUMBER_WIDTH-1] ? (~num_u + 1'b1) : num_u;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (!stat.base_ok) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CH_NUL;
            out_last_nxt  = 1'b1;
            out_err_nxt   = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            if (neg_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = CH_MINUS;
              out_last_nxt  = 1'b0;
              out_err_nxt   = 1'b0;
            end
            div_start = 1'b1;
            idx_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if ((div_quot != '0) && (idx_r != AW'(NUMBER_WIDTH - 1))) begin
            div_start = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = symbols[mem_rdata];
          out_last_nxt  = (idx_r == '0);
          out_err_nxt   = 1'b0;
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last_char  = out_last_r;
  assign out_base_error = out_err_r;

endmodule

### hdl/sde_cfg_regs.sv
// Configuration registers and alphabet validity check.
module sde_cfg_regs import sde_pkg::*; #(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output sym_array_t            symbols,
  output cfg_stat_t             stat
);

  logic [LEN_W-1:0]      base_length_r;
  logic [CFG_DATA_W-1:0] sym_word_r [NUM_WORDS];
  logic                  bad;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= '0;
      for (int w = 0; w < NUM_WORDS; w++) sym_word_r[w] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_LENGTH:   base_length_r <= cfg_wdata[LEN_W-1:0];
        REG_SYMBOL_WORD_0: sym_word_r[0] <= cfg_wdata;
        REG_SYMBOL_WORD_1: sym_word_r[1] <= cfg_wdata;
        REG_SYMBOL_WORD_2: sym_word_r[2] <= cfg_wdata;
        REG_SYMBOL_WORD_3: sym_word_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Slice the words into byte symbols, low byte first
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_sym
    assign symbols[i] = sym_word_r[i / WORD_SYMS][(i % WORD_SYMS) * SYM_W +: SYM_W];
  end

  // Forbidden symbols and duplicates among the symbols in use
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if ((LEN_W'(i) < base_length_r) && is_forbidden(symbols[i])) bad = 1'b1;
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if ((LEN_W'(j) < base_length_r) && (symbols[i] == symbols[j])) bad = 1'b1;
      end
    end
  end

  assign stat.radix   = base_length_r;
  assign stat.base_ok = !bad && (base_length_r >= LEN_W'(2)) &&
                        (base_length_r <= LEN_W'(MAX_SYMBOLS));

endmodule

### hdl/sde_divider.sv
// Shared iterative divider: magnitude by radix, several quotient bits a cycle.
module sde_divider import sde_pkg::*; #(
  parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [LEN_W-1:0]        divisor,
  output logic                    done,
  output logic [NUMBER_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]      remainder
);

  localparam int NSTEP = (NUMBER_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DW    = NSTEP * DIV_STEP;
  localparam int SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic               busy_r;
  logic               done_r;
  logic [SCW-1:0]     cnt_r;
  logic [DW-1:0]      q_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [LEN_W-1:0]   div_r;
  logic [DW-1:0]      q_step;
  logic [DIGIT_W-1:0] rem_step;

  // DIV_STEP restoring steps on the narrow remainder
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [DW-1:0]      q;
    logic [LEN_W-1:0]   t;
    r = rem_r;
    q = q_r;
    for (int k = 0; k < DIV_STEP; k++) begin
      t = {r, q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (t >= div_r) begin
        r    = DIGIT_W'(t - div_r);
        q[0] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
      end
    end
    q_step   = q;
    rem_step = r;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SCW'(NSTEP - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= DW'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_step;
      rem_r <= rem_step;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r[NUMBER_WIDTH-1:0];
  assign remainder = rem_r;

endmodule

### hdl/sde_digit_mem.sv
// Digit store: one write port, one registered read port.
module sde_digit_mem import sde_pkg::*; #(
  parameter int DEPTH = DEF_NUMBER_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/sde_checker.sv
// Port-level checker for the digit emitter, bound to the top level.
`include "signed_radix_digit_emitter_top_macros.svh"

module sde_checker import sde_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [SYM_W-1:0] out_character,
  input logic             out_last_char,
  input logic             out_base_error
);

  logic [SYM_W+1:0] out_payload;
  logic             stalled;
  logic             err_shape_ok;

  assign out_payload  = {out_character, out_last_char, out_base_error};
  assign stalled      = out_valid && !out_ready;
  assign err_shape_ok = out_last_char && (out_character == CH_NUL);

  // A stalled result holds
  `SDE_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_payload), "stall not held")

  // An error result is always the only and last one
  `SDE_ASSERT_NOW(a_err_last, out_valid && out_base_error, err_shape_ok, "bad error result")

  // The block is busy right after taking a number
  `SDE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

endmodule

bind signed_radix_digit_emitter_top sde_checker u_sde_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last_char (out_last_char),
  .out_base_error(out_base_error)
);
